// ===== src/assert_macros.svh =====
// assertion macros shared by the deframer rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: next cycle");

`endif

// ===== src/efd_pkg.sv =====
// types and constants of the escaped frame deframer
// no dependencies
package efd_pkg;

   localparam int BYTE_W      = 8;
   localparam int CHK_W       = 7;
   localparam int STATUS_W    = 2;
   localparam int PLEN_W      = 6;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int HDR_BYTES   = 5;

   localparam logic [1:0] REG_START  = 2'd0;
   localparam logic [1:0] REG_END    = 2'd1;
   localparam logic [1:0] REG_ESCAPE = 2'd2;
   localparam logic [1:0] REG_MASK   = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD_SUM  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_SHORT    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [BYTE_W-1:0] START_RESET  = 8'h02;
   localparam logic [BYTE_W-1:0] END_RESET    = 8'h03;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h1b;
   localparam logic [BYTE_W-1:0] MASK_RESET   = 8'h80;

   typedef struct packed {
      logic [BYTE_W-1:0] start_byte;
      logic [BYTE_W-1:0] end_byte;
      logic [BYTE_W-1:0] escape_byte;
      logic [BYTE_W-1:0] header_mask;
   } cfg_type;

endpackage

// ===== src/escaped_frame_deframer_checksum_top.sv =====
// escaped frame deframer with 7-bit additive checksum, top level
// depends on efd_pkg, efd_csr, efd_payload_ram, assert_macros.svh
// results: none inside a frame; after the end byte the drain starts, or the status goes out if no payload
// throughput: one byte per cycle in a frame; the drain emits each payload byte in S_READ then S_EMIT
//   (ram read then output load, waiting while the output is stalled), then the status transaction
// reset: synchronous, clears control state and loads the register reset values
`include "assert_macros.svh"
module escaped_frame_deframer_checksum_top
   import efd_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_kind,
   output logic [BYTE_W-1:0]     rsp_data,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [CHK_W-1:0]      rsp_computed_checksum,
   output logic [PLEN_W-1:0]     rsp_payload_length,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W  = $clog2(PAYLOAD_DEPTH + HDR_BYTES + 1);
   localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int LEN_W  = $clog2(PAYLOAD_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PAYLOAD_DEPTH + HDR_BYTES);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PAYLOAD_DEPTH);
   localparam logic [CNT_W-1:0] HDR_C   = CNT_W'(HDR_BYTES);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_READ   = 2'd1;
   localparam logic [1:0] S_EMIT   = 2'd2;
   localparam logic [1:0] S_STATUS = 2'd3;

   cfg_type cfg;

   logic [1:0]          state_ff, state_in;
   logic                in_frame_ff, in_frame_in;
   logic                esc_ff, esc_in;
   logic                have_raw_ff, have_raw_in;
   logic                ovf_ff, ovf_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic [BYTE_W-1:0]   raw_ff, raw_in;
   logic [BYTE_W-1:0]   unesc_ff, unesc_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CHK_W-1:0]    comp_ff, comp_in;
   logic [STATUS_W-1:0] stat_ff, stat_in;
   logic [LEN_W-1:0]    stored_ff, stored_in;
   logic [ADDR_W-1:0]   rd_idx_ff, rd_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CHK_W-1:0]    rsp_chk_ff, rsp_chk_in;
   logic [PLEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept, out_free, take, last_byte;
   logic [BYTE_W-1:0]   b, unesc_val;
   logic [CHK_W-1:0]    keep, comp_now, recv_now;
   logic [CNT_W-1:0]    slot, diff;
   logic [LEN_W-1:0]    stored_now;
   logic                ram_we, ram_re;
   logic [BYTE_W-1:0]   ram_rdata;

   efd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   efd_payload_ram #(
      .DEPTH  (PAYLOAD_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot[ADDR_W-1:0]),
      .wr_data (unesc_ff),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign b         = req_rx_byte;
   assign keep      = ~cfg.header_mask[CHK_W-1:0];
   assign unesc_val = esc_ff ? (b & ~cfg.header_mask) : b;
   assign take      = esc_ff || (b != cfg.escape_byte);
   assign slot      = count_ff - HDR_C;
   assign diff      = count_ff - HDR_C;
   assign comp_now  = sum_ff[CHK_W-1:0] & keep;
   assign recv_now  = raw_ff[CHK_W-1:0] & keep;
   assign stored_now = (count_ff < HDR_C) ? '0 :
                       (diff > DEPTH_C) ? LEN_W'(DEPTH_C) : LEN_W'(diff);
   assign last_byte = (LEN_W'(rd_idx_ff) + LEN_W'(1)) == stored_ff;
   assign ram_re    = (state_ff == S_READ);

   always_comb begin
      state_in      = state_ff;
      in_frame_in   = in_frame_ff;
      esc_in        = esc_ff;
      have_raw_in   = have_raw_ff;
      ovf_in        = ovf_ff;
      sum_in        = sum_ff;
      raw_in        = raw_ff;
      unesc_in      = unesc_ff;
      count_in      = count_ff;
      comp_in       = comp_ff;
      stat_in       = stat_ff;
      stored_in     = stored_ff;
      rd_idx_in     = rd_idx_ff;
      ram_we        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_chk_in    = rsp_chk_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!in_frame_ff) begin
                  if (b == cfg.start_byte) begin
                     in_frame_in = 1'b1;
                     esc_in      = 1'b0;
                     have_raw_in = 1'b0;
                     ovf_in      = 1'b0;
                     sum_in      = '0;
                     raw_in      = '0;
                     unesc_in    = b;
                     count_in    = CNT_W'(1);
                  end
               end else if (b == cfg.end_byte) begin
                  in_frame_in = 1'b0;
                  esc_in      = 1'b0;
                  comp_in     = comp_now;
                  stored_in   = stored_now;
                  rd_idx_in   = '0;
                  if (count_ff < HDR_C) begin
                     stat_in = STAT_SHORT;
                  end else if (comp_now != '0 && comp_now != recv_now) begin
                     stat_in = STAT_BAD_SUM;
                  end else if (ovf_ff) begin
                     stat_in = STAT_OVERFLOW;
                  end else begin
                     stat_in = STAT_OK;
                  end
                  state_in = (stored_now == '0) ? S_STATUS : S_READ;
               end else begin
                  if (have_raw_ff) begin
                     sum_in = sum_ff + raw_ff;
                  end
                  raw_in      = b;
                  have_raw_in = 1'b1;
                  if (esc_ff) begin
                     esc_in = 1'b0;
                  end else if (b == cfg.escape_byte) begin
                     esc_in = 1'b1;
                  end
                  if (take) begin
                     if (count_ff >= HDR_C) begin
                        if (slot < DEPTH_C) begin
                           ram_we = 1'b1;
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                     unesc_in = unesc_val;
                     if (count_ff < CNT_MAX) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
               end
            end
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_PAYLOAD;
               rsp_data_in   = ram_rdata;
               rsp_status_in = STAT_OK;
               rsp_chk_in    = '0;
               rsp_len_in    = PLEN_W'(stored_ff);
               rsp_last_in   = 1'b0;
               if (last_byte) begin
                  state_in = S_STATUS;
               end else begin
                  rd_idx_in = rd_idx_ff + ADDR_W'(1);
                  state_in  = S_READ;
               end
            end
         end
         S_STATUS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_STATUS;
               rsp_data_in   = '0;
               rsp_status_in = stat_ff;
               rsp_chk_in    = comp_ff;
               rsp_len_in    = PLEN_W'(stored_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_frame_ff  <= 1'b0;
         esc_ff       <= 1'b0;
         have_raw_ff  <= 1'b0;
         ovf_ff       <= 1'b0;
         sum_ff       <= '0;
         raw_ff       <= '0;
         unesc_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_frame_ff  <= in_frame_in;
         esc_ff       <= esc_in;
         have_raw_ff  <= have_raw_in;
         ovf_ff       <= ovf_in;
         sum_ff       <= sum_in;
         raw_ff       <= raw_in;
         unesc_ff     <= unesc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      comp_ff       <= comp_in;
      stat_ff       <= stat_in;
      stored_ff     <= stored_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chk_ff    <= rsp_chk_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = rsp_kind_ff;
   assign rsp_data              = rsp_data_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_computed_checksum = rsp_chk_ff;
   assign rsp_payload_length    = rsp_len_ff;
   assign rsp_last              = rsp_last_ff;

   // buffer writes only happen while receiving, never during a drain
   `ASSERT_IMPLY(a_no_write_in_drain, clock, reset, ram_we, state_ff == S_IDLE)
   // a read is always followed by the emit state, which consumes the ram data
   `ASSERT_NEXT(a_read_then_emit, clock, reset, state_ff == S_READ, state_ff == S_EMIT)
   // the drain never reads past the stored payload
   `ASSERT_IMPLY(a_read_in_range, clock, reset, state_ff == S_READ,
                 LEN_W'(rd_idx_ff) < stored_ff)
   // a frame close with payload starts a drain
   `ASSERT_NEXT(a_close_starts_drain, clock, reset,
                accept && in_frame_ff && b == cfg.end_byte && stored_now != '0,
                state_ff == S_READ)

endmodule

// ===== src/efd_csr.sv =====
// apb-style register file for the deframer byte codes and header mask
// depends on efd_pkg
module efd_csr
   import efd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;
   logic [1:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx = csr_paddr[3:2];
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_START:  cfg_in.start_byte  = csr_pwdata[BYTE_W-1:0];
            REG_END:    cfg_in.end_byte    = csr_pwdata[BYTE_W-1:0];
            REG_ESCAPE: cfg_in.escape_byte = csr_pwdata[BYTE_W-1:0];
            REG_MASK:   cfg_in.header_mask = csr_pwdata[BYTE_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_START:  csr_prdata = CSR_DATA_W'(cfg_ff.start_byte);
         REG_END:    csr_prdata = CSR_DATA_W'(cfg_ff.end_byte);
         REG_ESCAPE: csr_prdata = CSR_DATA_W'(cfg_ff.escape_byte);
         REG_MASK:   csr_prdata = CSR_DATA_W'(cfg_ff.header_mask);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte  <= START_RESET;
         cfg_ff.end_byte    <= END_RESET;
         cfg_ff.escape_byte <= ESCAPE_RESET;
         cfg_ff.header_mask <= MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/efd_payload_ram.sv =====
// payload byte buffer: one write port, one read port, registered read data
// depends on efd_pkg
module efd_payload_ram
   import efd_pkg::*;
#(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
